>>> rtl/hpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hpt_pkg: shared types and constants for the hashed page table insert block
// entry layout, row layout, classified command and stream field widths
// ----------------------------------------------------------------------------
package hpt_pkg;

    localparam int GROUP_BITS = 10;
    localparam int WAYS       = 8;
    localparam int WAY_W      = 3;
    localparam int ROWS       = 1 << GROUP_BITS;

    localparam int VADDR_W = 32;
    localparam int VSID_W  = 24;
    localparam int RPN_W   = 20;
    localparam int API_W   = 6;
    localparam int PAGE_W  = 16;
    localparam int SLOT_W  = 13;

    // virtual address bit positions
    localparam int PAGE_LSB = 12;
    localparam int API_LSB  = 22;

    localparam logic [1:0] PP_DEFAULT = 2'd2;

    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 16;
    localparam int OUT_PAD_W  = OUT_DATA_W - SLOT_W - 2;

    typedef struct packed {
        logic              valid;
        logic [VSID_W-1:0] vsid;
        logic              hsel;
        logic [API_W-1:0]  api;
        logic [RPN_W-1:0]  rpn;
        logic              refd;
        logic              chgd;
        logic [1:0]        prot;
    } pte_t;

    localparam int PTE_W = $bits(pte_t);
    localparam int ROW_W = WAYS * PTE_W;

    typedef pte_t [WAYS-1:0] row_t;

    // item after decode, handed from front to back
    typedef struct packed {
        logic [VSID_W-1:0]     vsid;
        logic [API_W-1:0]      api;
        logic [RPN_W-1:0]      rpn;
        logic [WAY_W-1:0]      page_way;
        logic [GROUP_BITS-1:0] prim_group;
        logic [GROUP_BITS-1:0] sec_group;
    } cmd_t;

    localparam int CMD_W = $bits(cmd_t);

endpackage
`default_nettype wire

>>> rtl/hashed_page_table_insert.sv
`timescale 1ns / 1ps
`default_nettype none
// path from input transfer to m_axis_tvalid: input register, queue, then table
// engine (pickup with primary read, secondary read, pick way, write)
// the table engine takes no new item until its four steps for the last are done
// reset: after rst_n rises the table is cleared one group row a cycle, all 1024
// rows, with s_axis_tready held low until the pass is done
// ----------------------------------------------------------------------------
// hashed_page_table_insert: hashed page table insert engine
// inserts one translation per item into a group-of-eight hashed table
// ----------------------------------------------------------------------------
module hashed_page_table_insert
    import hpt_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // vaddr[31:0], segment_id[55:32], frame_number[75:56], zero pad
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // slot_index[12:0], used_secondary[13], replaced_valid[14], zero pad
    output logic      [OUT_DATA_W-1:0] m_axis_tdata
);

    logic table_busy;
    logic front_valid;
    logic front_ready;
    cmd_t front_cmd;
    logic q_valid;
    logic q_ready;
    cmd_t q_cmd;

    hpt_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .table_busy    (table_busy),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .cmd_valid     (front_valid),
        .cmd_ready     (front_ready),
        .cmd           (front_cmd)
    );

    hpt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_cmd   (front_cmd),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_cmd    (q_cmd)
    );

    hpt_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .table_busy    (table_busy),
        .cmd_valid     (q_valid),
        .cmd_ready     (q_ready),
        .cmd           (q_cmd),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
`default_nettype wire

>>> rtl/hpt_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hpt_ram: generic single-write, single-read memory
// one write port and one read port with registered read data
// ----------------------------------------------------------------------------
module hpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

>>> rtl/hpt_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hpt_front: input stage
// takes the input transfer, works out page, api and both hash groups
// ----------------------------------------------------------------------------
module hpt_front
    import hpt_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 table_busy,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [IN_DATA_W-1:0] s_axis_tdata,
    output logic                      cmd_valid,
    input  wire logic                 cmd_ready,
    output cmd_t                      cmd
);

    logic [VADDR_W-1:0] vaddr;
    logic [VSID_W-1:0]  segment_id;
    logic [RPN_W-1:0]   frame_number;
    logic [PAGE_W-1:0]  page;
    logic [VSID_W-1:0]  hash;
    cmd_t               cmd_next;
    logic               valid_reg;
    cmd_t               cmd_reg;

    assign vaddr        = s_axis_tdata[VADDR_W-1:0];
    assign segment_id   = s_axis_tdata[VADDR_W +: VSID_W];
    assign frame_number = s_axis_tdata[VADDR_W+VSID_W +: RPN_W];

    always_comb
    begin
        page                = vaddr[PAGE_LSB +: PAGE_W];
        hash                = segment_id ^ VSID_W'(page);
        cmd_next.vsid       = segment_id;
        cmd_next.api        = vaddr[API_LSB +: API_W];
        cmd_next.rpn        = frame_number;
        cmd_next.page_way   = page[WAY_W-1:0];
        cmd_next.prim_group = hash[GROUP_BITS-1:0];
        cmd_next.sec_group  = ~hash[GROUP_BITS-1:0];
    end

    assign s_axis_tready = !table_busy && (!valid_reg || cmd_ready);
    assign cmd_valid     = valid_reg;
    assign cmd           = cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            valid_reg <= s_axis_tvalid;
        end
        else if (cmd_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/hpt_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hpt_queue: two-entry command queue
// decouples the input stage from the table engine
// ----------------------------------------------------------------------------
module hpt_queue
    import hpt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    output logic      push_ready,
    input  wire cmd_t push_cmd,
    output logic      pop_valid,
    input  wire logic pop_ready,
    output cmd_t      pop_cmd
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

>>> rtl/hpt_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hpt_back: table engine
// clears the table after reset, then reads both groups, picks a way and
// writes the new entry; result sits in an output register
// ----------------------------------------------------------------------------
module hpt_back
    import hpt_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    output logic                       table_busy,
    input  wire logic                  cmd_valid,
    output logic                       cmd_ready,
    input  wire cmd_t                  cmd,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_PRI,
        ST_RD_SEC,
        ST_WRITE
    } state_t;

    state_t                state_reg;
    logic [GROUP_BITS-1:0] clr_addr_reg;
    cmd_t                  cmd_reg;
    row_t                  prim_row_reg;
    row_t                  sec_row_reg;
    logic [WAY_W-1:0]      way_reg;
    logic                  use_sec_reg;
    logic                  replaced_reg;
    logic                  out_valid_reg;
    logic [SLOT_W-1:0]     out_slot_reg;
    logic                  out_sec_reg;
    logic                  out_repl_reg;

    logic                  ram_we;
    logic [GROUP_BITS-1:0] ram_waddr;
    logic [ROW_W-1:0]      ram_wdata;
    logic                  ram_re;
    logic [GROUP_BITS-1:0] ram_raddr;
    logic [ROW_W-1:0]      ram_rdata;
    row_t                  rd_row;

    logic                  prim_found;
    logic [WAY_W-1:0]      prim_way;
    logic                  prim_repl;
    logic                  sec_found;
    logic [WAY_W-1:0]      sec_way;
    logic [WAY_W-1:0]      way_next;
    logic                  use_sec_next;
    logic                  replaced_next;

    pte_t                  new_entry;
    row_t                  new_row;
    logic [GROUP_BITS-1:0] wr_group;
    logic                  fire;

    hpt_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROWS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_row     = row_t'(ram_rdata);
    assign table_busy = (state_reg == ST_CLEAR);
    assign cmd_ready  = (state_reg == ST_IDLE);
    assign fire       = (state_reg == ST_WRITE) && (!out_valid_reg || m_axis_tready);

    // way search over the primary row (registered) and secondary row (just read)
    always_comb
    begin
        prim_found = 1'b0;
        prim_way   = '0;
        prim_repl  = 1'b0;
        sec_found  = 1'b0;
        sec_way    = '0;
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if (!prim_row_reg[i].valid ||
                (prim_row_reg[i].vsid == cmd_reg.vsid && prim_row_reg[i].api == cmd_reg.api))
            begin
                prim_found = 1'b1;
                prim_way   = WAY_W'(i);
                prim_repl  = prim_row_reg[i].valid;
            end
            if (!rd_row[i].valid)
            begin
                sec_found = 1'b1;
                sec_way   = WAY_W'(i);
            end
        end

        priority if (prim_found)
        begin
            way_next      = prim_way;
            use_sec_next  = 1'b0;
            replaced_next = prim_repl;
        end
        else if (sec_found)
        begin
            way_next      = sec_way;
            use_sec_next  = 1'b1;
            replaced_next = 1'b0;
        end
        else
        begin
            way_next      = cmd_reg.page_way;
            use_sec_next  = 1'b0;
            replaced_next = prim_row_reg[cmd_reg.page_way].valid;
        end
    end

    always_comb
    begin
        new_entry.valid = 1'b1;
        new_entry.vsid  = cmd_reg.vsid;
        new_entry.hsel  = use_sec_reg;
        new_entry.api   = cmd_reg.api;
        new_entry.rpn   = cmd_reg.rpn;
        new_entry.refd  = 1'b0;
        new_entry.chgd  = 1'b0;
        new_entry.prot  = PP_DEFAULT;
        new_row         = use_sec_reg ? sec_row_reg : prim_row_reg;
        new_row[way_reg] = new_entry;
        wr_group        = use_sec_reg ? cmd_reg.sec_group : cmd_reg.prim_group;
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = wr_group;
        ram_wdata = ROW_W'(new_row);
        ram_re    = 1'b0;
        ram_raddr = cmd.prim_group;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = '0;
            end
            ST_IDLE:
            begin
                ram_re = cmd_valid;
            end
            ST_RD_PRI:
            begin
                ram_re    = 1'b1;
                ram_raddr = cmd_reg.sec_group;
            end
            ST_RD_SEC:
            begin
                ram_re = 1'b0;
            end
            ST_WRITE:
            begin
                ram_we = fire;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == '1)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        cmd_reg   <= cmd;
                        state_reg <= ST_RD_PRI;
                    end
                end
                ST_RD_PRI:
                begin
                    prim_row_reg <= rd_row;
                    state_reg    <= ST_RD_SEC;
                end
                ST_RD_SEC:
                begin
                    sec_row_reg  <= rd_row;
                    way_reg      <= way_next;
                    use_sec_reg  <= use_sec_next;
                    replaced_reg <= replaced_next;
                    state_reg    <= ST_WRITE;
                end
                ST_WRITE:
                begin
                    if (fire)
                    begin
                        out_valid_reg <= 1'b1;
                        out_slot_reg  <= SLOT_W'({wr_group, way_reg});
                        out_sec_reg   <= use_sec_reg;
                        out_repl_reg  <= replaced_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_repl_reg, out_sec_reg, out_slot_reg};

endmodule
`default_nettype wire

>>> sim/hpt_insert_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpt_insert_checker: scoreboard for the hashed page table insert block
// keeps a shadow copy of the page table, works out the slot that each
// accepted insert lands in and compares it with the result stream in order
// ----------------------------------------------------------------------------
module hpt_insert_checker
    import hpt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    // vaddr[31:0], segment_id[55:32], frame_number[75:56], zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // slot_index[12:0], used_secondary[13], replaced_valid[14], zero pad
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,
    output int                    fail_count,
    output int                    pending,
    output int                    checked,
    output int                    secondary_seen,
    output int                    replaced_seen
);

    localparam int TABLE_DEPTH = WAYS << GROUP_BITS;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              secondary;
        logic              replaced;
    } placement_t;

    pte_t       shadow_table [TABLE_DEPTH];
    placement_t placements_due [$];

    function automatic placement_t place_translation(
        input logic [VADDR_W-1:0] va,
        input logic [VSID_W-1:0]  vs,
        input logic [RPN_W-1:0]   frame
    );
        logic [PAGE_W-1:0]     page;
        logic [API_W-1:0]      api;
        logic [VSID_W-1:0]     hash;
        logic [GROUP_BITS-1:0] grp;
        logic [GROUP_BITS-1:0] alt_grp;
        logic [WAY_W-1:0]      way;
        logic                  hit;
        logic                  sec;
        logic                  repl;
        int                    idx;
        pte_t                  e;
        placement_t            p;
        page    = va[PAGE_LSB +: PAGE_W];
        api     = va[API_LSB +: API_W];
        hash    = vs ^ VSID_W'(page);
        grp     = hash[GROUP_BITS-1:0];
        alt_grp = ~grp;
        way     = '0;
        hit     = 1'b0;
        sec     = 1'b0;
        repl    = 1'b0;
        // primary group: free slot or same vsid and api, h bit ignored
        for (int w = 0; w < WAYS; w++)
        begin
            e = shadow_table[grp * WAYS + w];
            if (!hit && (!e.valid || (e.vsid == vs && e.api == api)))
            begin
                hit  = 1'b1;
                repl = e.valid;
                way  = WAY_W'(w);
            end
        end
        // secondary group only takes a free slot
        for (int w = 0; w < WAYS; w++)
        begin
            if (!hit && !shadow_table[alt_grp * WAYS + w].valid)
            begin
                hit = 1'b1;
                sec = 1'b1;
                grp = alt_grp;
                way = WAY_W'(w);
            end
        end
        // both groups full: evict primary way chosen by the page
        if (!hit)
        begin
            way  = page[WAY_W-1:0];
            repl = shadow_table[grp * WAYS + way].valid;
        end
        idx     = grp * WAYS + way;
        e       = '0;
        e.valid = 1'b1;
        e.vsid  = vs;
        e.hsel  = sec;
        e.api   = api;
        e.rpn   = frame;
        e.prot  = PP_DEFAULT;
        shadow_table[idx] = e;
        p.slot      = SLOT_W'(idx);
        p.secondary = sec;
        p.replaced  = repl;
        return p;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : scoreboard
        placement_t want;
        placement_t got;
        int         errs;
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
                shadow_table[i] = '0;
            placements_due.delete();
            fail_count     <= 0;
            pending        <= 0;
            checked        <= 0;
            secondary_seen <= 0;
            replaced_seen  <= 0;
        end
        else
        begin
            errs = 0;
            if (s_axis_tvalid && s_axis_tready)
                placements_due.push_back(place_translation(
                    s_axis_tdata[0 +: VADDR_W],
                    s_axis_tdata[VADDR_W +: VSID_W],
                    s_axis_tdata[VADDR_W + VSID_W +: RPN_W]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.slot      = m_axis_tdata[SLOT_W-1:0];
                got.secondary = m_axis_tdata[SLOT_W];
                got.replaced  = m_axis_tdata[SLOT_W + 1];
                if (placements_due.size() == 0)
                begin
                    $error("result transfer with no insert outstanding: slot_index %0d",
                           got.slot);
                    errs++;
                end
                else
                begin
                    want = placements_due.pop_front();
                    if (got.slot != want.slot)
                    begin
                        $error("slot_index: expected %0d, got %0d", want.slot, got.slot);
                        errs++;
                    end
                    if (got.secondary != want.secondary)
                    begin
                        $error("used_secondary: expected %0d, got %0d",
                               want.secondary, got.secondary);
                        errs++;
                    end
                    if (got.replaced != want.replaced)
                    begin
                        $error("replaced_valid: expected %0d, got %0d",
                               want.replaced, got.replaced);
                        errs++;
                    end
                end
                checked        <= checked + 1;
                secondary_seen <= secondary_seen + got.secondary;
                replaced_seen  <= replaced_seen + got.replaced;
            end
            fail_count <= fail_count + errs;
            pending    <= placements_due.size();
        end
    end

endmodule

>>> sim/tb_hashed_page_table_insert.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hashed_page_table_insert: testbench for the hashed page table insert block
// directed fills of one group pair, then random inserts aimed at a few hot
// groups with repeated translations, random idling on both streams
// ----------------------------------------------------------------------------
module tb_hashed_page_table_insert;
    import hpt_pkg::*;

    localparam int RANDOM_ITEMS = 1850;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOT_COUNT    = 6;
    localparam int RECENT_MAX   = 32;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    int fail_count;
    int pending;
    int checked;
    int secondary_seen;
    int replaced_seen;

    int   cycles = 0;
    int   items_sent;
    int   stall_left;
    logic quiet;

    logic [GROUP_BITS-1:0] hot_groups [HOT_COUNT];
    logic [VSID_W-1:0]     recent_vsid [$];
    logic [VADDR_W-1:0]    recent_vaddr [$];

    hashed_page_table_insert dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    hpt_insert_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .fail_count     (fail_count),
        .pending        (pending),
        .checked        (checked),
        .secondary_seen (secondary_seen),
        .replaced_seen  (replaced_seen)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb_hashed_page_table_insert: FAIL");
            $finish;
        end
    end

    // result side: after each transfer hold off for a random number of cycles
    always @(posedge clk or negedge rst_n)
    begin : result_sink
        int n;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            n = quiet ? 0 : $urandom_range(0, 9);
            m_axis_tready <= (n == 0);
            stall_left    <= n;
        end
        else if (!m_axis_tready)
        begin
            if (stall_left <= 1)
                m_axis_tready <= 1'b1;
            else
                stall_left <= stall_left - 1;
        end
    end

    task automatic send_insert(
        input logic [VADDR_W-1:0] va,
        input logic [VSID_W-1:0]  vs,
        input logic [RPN_W-1:0]   frame
    );
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_DATA_W - VADDR_W - VSID_W - RPN_W){1'b0}}, frame, vs, va};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
        recent_vsid.push_back(vs);
        recent_vaddr.push_back(va);
        if (recent_vsid.size() > RECENT_MAX)
        begin
            void'(recent_vsid.pop_front());
            void'(recent_vaddr.pop_front());
        end
    endtask

    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    initial
    begin : stimulus
        logic [VADDR_W-1:0]    va;
        logic [VSID_W-1:0]     vs;
        logic [RPN_W-1:0]      frame;
        logic [GROUP_BITS-1:0] g;
        int                    pick;
        int                    k;
        items_sent    = 0;
        quiet         = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        send_insert('0, '0, '0);
        send_insert('1, '1, '1);
        // same vsid and api as the all-ones insert: overwritten in place
        send_insert(32'h0fff_f123, '1, 20'h5a5a5);
        // fill primary group 5, then its secondary group, then evict
        for (k = 0; k < 2 * WAYS; k++)
            send_insert(VADDR_W'(k) << API_LSB, (VSID_W'(k) << 10) | VSID_W'(5),
                        RPN_W'($urandom));
        send_insert(32'h0000_3000, 24'h0a_0006, 20'h12345);
        send_insert(32'hf000_3abc, 24'h0a_0006, 20'h6789a);
        send_insert('0, 24'h00_03ff, 20'h80001);
        wait_results_drained();

        hot_groups[0] = '0;
        hot_groups[1] = '1;
        for (k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k % 256 == 0)
            begin
                hot_groups[2] = GROUP_BITS'($urandom);
                hot_groups[3] = ~hot_groups[2];
                hot_groups[4] = GROUP_BITS'($urandom);
                hot_groups[5] = GROUP_BITS'($urandom);
            end
            if (k == RANDOM_ITEMS / 2)
                wait_results_drained();
            quiet <= (k % 128) < 20;
            pick  = $urandom_range(0, 99);
            frame = RPN_W'($urandom);
            va    = $urandom;
            vs    = VSID_W'($urandom);
            if (pick < 35 && pick >= 10 && recent_vsid.size() > 0)
            begin
                // revisit a recent translation so it can be found again
                pick = $urandom_range(0, recent_vsid.size() - 1);
                vs   = recent_vsid[pick];
                va[PAGE_LSB +: PAGE_W] = recent_vaddr[pick][PAGE_LSB +: PAGE_W];
            end
            else if (pick >= 10)
            begin
                g = hot_groups[$urandom_range(0, HOT_COUNT - 1)];
                va[PAGE_LSB +: GROUP_BITS] = g ^ vs[GROUP_BITS-1:0];
            end
            send_insert(va, vs, frame);
        end
        wait_results_drained();
        repeat (20) @(posedge clk);

        $display("inserts sent: %0d, results checked: %0d", items_sent, checked);
        $display("placed in a secondary group: %0d, overwrote a valid entry: %0d",
                 secondary_seen, replaced_seen);
        if (fail_count == 0 && pending == 0)
            $display("tb_hashed_page_table_insert: PASS");
        else
            $display("tb_hashed_page_table_insert: FAIL");
        $finish;
    end

endmodule

>>> hashed_page_table_insert.f
rtl/hpt_pkg.sv
rtl/hpt_ram.sv
rtl/hpt_front.sv
rtl/hpt_queue.sv
rtl/hpt_back.sv
rtl/hashed_page_table_insert.sv
sim/hpt_insert_checker.sv
sim/tb_hashed_page_table_insert.sv
